FILE: rtl/core/nls_pkg.sv
// Shared types and codes for the numeric literal scanner.
// Holds the payload structs, the scanner state encoding and the result status codes.
// Depends on nothing.
package nls_pkg;

  // Character codes the recognizer looks for.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharUpE   = 8'h45;
  localparam logic [7:0] CharLowE  = 8'h65;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CaseBit   = 8'h20;

  // Recognizer states, one-hot.
  typedef enum logic [7:0] {
    ST_START   = 8'b0000_0001,
    ST_MINUS   = 8'b0000_0010,
    ST_ZERO    = 8'b0000_0100,
    ST_PERIOD  = 8'b0000_1000,
    ST_MANT    = 8'b0001_0000,
    ST_EXP     = 8'b0010_0000,
    ST_EXPSIGN = 8'b0100_0000,
    ST_EXPDIG  = 8'b1000_0000
  } scan_state_t;

  // Result status codes.
  typedef enum logic [3:0] {
    RES_TAKEN       = 4'd0,
    RES_ENDED       = 4'd1,
    RES_NONUM       = 4'd2,
    RES_NEGATE      = 4'd3,
    RES_DROP        = 4'd4,
    RES_ERR_ZERO    = 4'd5,
    RES_ERR_PERIOD  = 4'd6,
    RES_ERR_EXP     = 4'd7,
    RES_ERR_EXPSIGN = 4'd8
  } status_t;

  // One input item.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0] status;
    logic       is_double;
    logic [7:0] taken_char;
  } out_item_t;

  // Scanner context carried between items.
  typedef struct packed {
    scan_state_t state;
    logic        dbl;
  } scan_ctx_t;

endpackage

FILE: rtl/core/nls_step.sv
// Combinational transition of the numeric literal recognizer for one character.
// Produces the result item and the context for the next character.
// Depends on nls_pkg.
module nls_step (
  input  nls_pkg::in_item_t  item,
  input  nls_pkg::scan_ctx_t ctx,
  output nls_pkg::out_item_t result,
  output nls_pkg::scan_ctx_t ctx_nxt
);
  import nls_pkg::*;

  logic       eoi;
  logic [7:0] c;
  logic [7:0] c_low;
  logic       is_digit;
  logic       is_alpha;
  logic       is_e;
  logic       is_dot;
  logic       is_minus;
  logic       is_plus;
  logic       is_zero;
  status_t    status;
  logic       dbl_res;
  scan_ctx_t  ctx_tmp;

  // Character classes; end of input matches no class.
  assign eoi      = item.end_of_input;
  assign c        = item.char_code;
  assign c_low    = c | CaseBit;
  assign is_digit = !eoi && (c >= CharZero) && (c <= CharNine);
  assign is_alpha = !eoi && (c_low >= CharLowA) && (c_low <= CharLowZ);
  assign is_e     = !eoi && ((c == CharUpE) || (c == CharLowE));
  assign is_dot   = !eoi && (c == CharDot);
  assign is_minus = !eoi && (c == CharMinus);
  assign is_plus  = !eoi && (c == CharPlus);
  assign is_zero  = !eoi && (c == CharZero);

  // State transitions. The leading-zero period case folds the re-run in the mantissa.
  always_comb begin
    ctx_tmp = ctx;
    status  = RES_ENDED;
    dbl_res = ctx.dbl;
    case (ctx.state)
      ST_START: begin
        if (is_zero) begin
          ctx_tmp.state = ST_ZERO;
          status        = RES_TAKEN;
        end else if (is_minus) begin
          ctx_tmp.state = ST_MINUS;
          status        = RES_TAKEN;
        end else if (is_dot) begin
          ctx_tmp.state = ST_PERIOD;
          ctx_tmp.dbl   = 1'b1;
          dbl_res       = 1'b1;
          status        = RES_TAKEN;
        end else if (is_digit) begin
          ctx_tmp.state = ST_MANT;
          status        = RES_TAKEN;
        end else begin
          status  = RES_NONUM;
          dbl_res = 1'b0;
        end
      end
      ST_MINUS: begin
        if (is_dot) begin
          ctx_tmp.state = ST_PERIOD;
          ctx_tmp.dbl   = 1'b1;
          dbl_res       = 1'b1;
          status        = RES_TAKEN;
        end else if (is_digit) begin
          ctx_tmp.state = ST_MANT;
          status        = RES_TAKEN;
        end else begin
          status  = RES_NEGATE;
          dbl_res = 1'b0;
        end
      end
      ST_ZERO: begin
        if (is_dot) begin
          if (!ctx.dbl) begin
            ctx_tmp.state = ST_MANT;
            ctx_tmp.dbl   = 1'b1;
            dbl_res       = 1'b1;
            status        = RES_TAKEN;
          end else begin
            status = RES_ENDED;
          end
        end else if (is_digit) begin
          status = RES_ERR_ZERO;
        end else begin
          status = RES_ENDED;
        end
      end
      ST_PERIOD: begin
        if (is_digit) begin
          ctx_tmp.state = ST_MANT;
          status        = RES_TAKEN;
        end else begin
          status = RES_ERR_PERIOD;
        end
      end
      ST_MANT: begin
        if (is_dot && !ctx.dbl) begin
          ctx_tmp.dbl = 1'b1;
          dbl_res     = 1'b1;
          status      = RES_TAKEN;
        end else if (is_e) begin
          ctx_tmp.state = ST_EXP;
          status        = RES_TAKEN;
        end else if (is_digit) begin
          status = RES_TAKEN;
        end else begin
          status = RES_ENDED;
        end
      end
      ST_EXP: begin
        if (is_minus || is_plus) begin
          ctx_tmp.state = ST_EXPSIGN;
          ctx_tmp.dbl   = 1'b1;
          dbl_res       = 1'b1;
          status        = RES_TAKEN;
        end else if (is_digit) begin
          ctx_tmp.state = ST_EXPDIG;
          ctx_tmp.dbl   = 1'b1;
          dbl_res       = 1'b1;
          status        = RES_TAKEN;
        end else if (is_alpha) begin
          status = RES_DROP;
        end else begin
          status = RES_ERR_EXP;
        end
      end
      ST_EXPSIGN: begin
        if (is_digit) begin
          ctx_tmp.state = ST_EXPDIG;
          status        = RES_TAKEN;
        end else begin
          status = RES_ERR_EXPSIGN;
        end
      end
      ST_EXPDIG: begin
        if (is_digit) begin
          status = RES_TAKEN;
        end else begin
          status = RES_ENDED;
        end
      end
      default: begin
        // Unreachable encodings behave like the exponent digits state.
        if (is_digit) begin
          status = RES_TAKEN;
        end else begin
          status = RES_ENDED;
        end
      end
    endcase
  end

  // Any ending returns to start with the flags cleared.
  always_comb begin
    ctx_nxt = ctx_tmp;
    if (status != RES_TAKEN) begin
      ctx_nxt.state = ST_START;
      ctx_nxt.dbl   = 1'b0;
    end
    result.status     = status;
    result.is_double  = dbl_res;
    result.taken_char = (status == RES_TAKEN) ? c : 8'h00;
  end

endmodule

FILE: rtl/core/numeric_literal_scanner_core.sv
// Top level of the numeric literal scanner: input register, recognizer step, result register.
// Depends on nls_pkg and nls_step.
//
// Each accepted character or end-of-input mark yields exactly one result item, in order.
// An item is captured in the input register, then passes through the recognizer step and lands in
// the result register once that register is free or draining, from where it is transferred out.
// One item is taken per cycle while the result side accepts; the recognizer context (state and
// double flag) updates in the same cycle the item moves into the result register, which sets
// that rate. Backpressure on the result side stalls the input register only once both registers
// are full. There are no configuration registers.
module numeric_literal_scanner_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nls_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nls_pkg::out_item_t  out_data
);
  import nls_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  scan_ctx_t ctx_r;
  scan_ctx_t ctx_nxt;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t step_result;
  logic      step_fire;

  // The step fires when an item waits and the result register is free or draining.
  assign step_fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step_fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  nls_step u_step (
    .item    (in_item_r),
    .ctx     (ctx_r),
    .result  (step_result),
    .ctx_nxt (ctx_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // Recognizer context advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state <= ST_START;
      ctx_r.dbl   <= 1'b0;
    end else if (step_fire) begin
      ctx_r <= ctx_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_item_r <= step_result;
    end
  end

  // A result that ends the token leaves the context at start with no double flag.
  a_end_resets_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && (step_result.status != RES_TAKEN)
    |=> (ctx_r.state == ST_START) && !ctx_r.dbl)
    else $error("context not cleared after a token ending");

  // Only a taken character carries a character code.
  a_char_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status != RES_TAKEN) |-> (out_item_r.taken_char == 8'h00))
    else $error("character code on a non-taken result");

  // No number and negate operator always report integer type.
  a_nonum_integer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((out_item_r.status == RES_NONUM) || (out_item_r.status == RES_NEGATE))
    |-> !out_item_r.is_double)
    else $error("double type reported without a number");

  // Past the exponent sign or into exponent digits the number is always a double.
  a_exp_is_double: assert property (@(posedge clk) disable iff (!rst_n)
    (ctx_r.state == ST_EXPSIGN) || (ctx_r.state == ST_EXPDIG) |-> ctx_r.dbl)
    else $error("exponent state without the double flag");

endmodule

FILE: tb/numeric_literal_scanner_core_tb.sv
// Self-checking testbench for numeric_literal_scanner_core: directed and random character streams.
// Results are checked against a scanner model kept in step here; depends on nls_pkg and the core.
`timescale 1ns / 100ps

module numeric_literal_scanner_core_tb;
  import nls_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Characters waiting to be sent and results the scanner still owes.
  in_item_t  chars_to_send[$];
  out_item_t scan_results_due[$];

  // Scanner context as the testbench tracks it.
  scan_state_t track_state = ST_START;
  logic        track_dbl = 1'b0;

  int fail_count = 0;
  int items_queued = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_cycle = 0;
  int ready_mode = 0;
  logic mid_drained = 1'b0;

  numeric_literal_scanner_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Runs one character through the tracked scanner and returns the result it must produce.
  function automatic out_item_t scan_char(in_item_t item);
    logic [7:0]  c;
    logic        eoi, is_digit, is_alpha, is_e, is_dot, is_minus, is_plus, is_zero;
    status_t     st;
    logic        dbl, nxt_dbl;
    scan_state_t nxt;
    out_item_t   res;
    c        = item.char_code;
    eoi      = item.end_of_input;
    is_digit = !eoi && c >= CharZero && c <= CharNine;
    is_alpha = !eoi && (c | CaseBit) >= CharLowA && (c | CaseBit) <= CharLowZ;
    is_e     = !eoi && (c == CharUpE || c == CharLowE);
    is_dot   = !eoi && c == CharDot;
    is_minus = !eoi && c == CharMinus;
    is_plus  = !eoi && c == CharPlus;
    is_zero  = !eoi && c == CharZero;
    st       = RES_TAKEN;
    dbl      = track_dbl;
    nxt      = track_state;
    nxt_dbl  = track_dbl;
    case (track_state)
      ST_START: begin
        if (is_zero) nxt = ST_ZERO;
        else if (is_minus) nxt = ST_MINUS;
        else if (is_dot) begin
          nxt = ST_PERIOD;
          dbl = 1'b1;
          nxt_dbl = 1'b1;
        end else if (is_digit) nxt = ST_MANT;
        else begin
          st = RES_NONUM;
          dbl = 1'b0;
        end
      end
      ST_MINUS: begin
        if (is_dot) begin
          nxt = ST_PERIOD;
          dbl = 1'b1;
          nxt_dbl = 1'b1;
        end else if (is_digit) nxt = ST_MANT;
        else begin
          st = RES_NEGATE;
          dbl = 1'b0;
        end
      end
      ST_ZERO: begin
        // A period after a leading zero continues as a mantissa.
        if (is_dot) begin
          nxt = ST_MANT;
          if (!track_dbl) begin
            dbl = 1'b1;
            nxt_dbl = 1'b1;
          end else st = RES_ENDED;
        end else if (is_digit) st = RES_ERR_ZERO;
        else st = RES_ENDED;
      end
      ST_PERIOD: begin
        if (is_digit) nxt = ST_MANT;
        else st = RES_ERR_PERIOD;
      end
      ST_MANT: begin
        // A second period ends the number.
        if (is_dot && !track_dbl) begin
          dbl = 1'b1;
          nxt_dbl = 1'b1;
        end else if (is_e) nxt = ST_EXP;
        else if (!is_digit) st = RES_ENDED;
      end
      ST_EXP: begin
        if (is_minus || is_plus) begin
          nxt = ST_EXPSIGN;
          dbl = 1'b1;
          nxt_dbl = 1'b1;
        end else if (is_digit) begin
          nxt = ST_EXPDIG;
          dbl = 1'b1;
          nxt_dbl = 1'b1;
        end else if (is_alpha) st = RES_DROP;
        else st = RES_ERR_EXP;
      end
      ST_EXPSIGN: begin
        if (is_digit) nxt = ST_EXPDIG;
        else st = RES_ERR_EXPSIGN;
      end
      default: begin
        if (!is_digit) st = RES_ENDED;
      end
    endcase
    // Any ending sends the scanner back to start with the flag cleared.
    if (st != RES_TAKEN) begin
      nxt = ST_START;
      nxt_dbl = 1'b0;
    end
    track_state    = nxt;
    track_dbl      = nxt_dbl;
    res.status     = st;
    res.is_double  = dbl;
    res.taken_char = (st == RES_TAKEN) ? c : 8'h00;
    return res;
  endfunction

  task automatic add_item(logic [7:0] c, logic eoi);
    in_item_t item;
    item.char_code    = c;
    item.end_of_input = eoi;
    chars_to_send.push_back(item);
    items_queued++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_digit();
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  // A mostly well-formed literal with random digits, followed by a random terminator.
  task automatic add_number_token();
    logic [7:0] term;
    if ($urandom_range(0, 3) == 0) add_item(CharMinus, 1'b0);
    case ($urandom_range(0, 3))
      0: add_item(CharZero, 1'b0);
      1: begin
        add_item(CharDot, 1'b0);
        repeat ($urandom_range(0, 3)) add_item(rand_digit(), 1'b0);
      end
      default: repeat ($urandom_range(1, 4)) add_item(rand_digit(), 1'b0);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      add_item(CharDot, 1'b0);
      repeat ($urandom_range(0, 3)) add_item(rand_digit(), 1'b0);
    end
    if ($urandom_range(0, 2) == 0) begin
      add_item($urandom_range(0, 1) ? CharUpE : CharLowE, 1'b0);
      case ($urandom_range(0, 3))
        0: add_item(CharMinus, 1'b0);
        1: add_item(CharPlus, 1'b0);
        default: ;
      endcase
      repeat ($urandom_range(0, 3)) add_item(rand_digit(), 1'b0);
    end
    // Terminator: end of input, a letter, punctuation or any byte.
    case ($urandom_range(0, 5))
      0: add_item(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        term = CharLowA + 8'($urandom_range(0, 25));
        add_item($urandom_range(0, 1) ? (term & ~CaseBit) : term, 1'b0);
      end
      2: add_item(8'h20, 1'b0);
      3: add_item(CharDot, 1'b0);
      default: add_item(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  // Waits until the sender has nothing left and every result has come back.
  task automatic wait_drained();
    while (chars_to_send.size() != 0 || in_valid || scan_results_due.size() != 0)
      @(negedge clk);
  endtask

  // Sender: bursts of transfers separated by random gaps; predicts each accepted character.
  always @(posedge clk) begin
    logic     nxt_valid;
    in_item_t nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        scan_results_due.push_back(scan_char(in_data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (chars_to_send.size() != 0) begin
          nxt_data  = chars_to_send.pop_front();
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= nxt_valid;
      in_data <= nxt_data;
    end
  end

  // Receiver: the stall pattern is redrawn at random among four shapes.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      ready_cycle++;
      if (ready_cycle % 256 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= (ready_cycle % 5 != 0);
        default: out_ready <= (ready_cycle % 24 >= 18);
      endcase
    end
  end

  // Monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (scan_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result status %0d is_double %0b taken_char %02h",
                   $time, out_data.status, out_data.is_double, out_data.taken_char);
      end else begin
        want = scan_results_due.pop_front();
        if (out_data.status !== want.status || out_data.is_double !== want.is_double ||
            out_data.taken_char !== want.taken_char) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: status exp %0d got %0d, is_double exp %0b got %0b, %s %02h got %02h",
                     $time, want.status, out_data.status, want.is_double, out_data.is_double,
                     "taken_char exp", want.taken_char, out_data.taken_char);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: end of input at start, full literals, each error and each kind of ending.
    add_item(8'hA5, 1'b1);
    add_text("0.5e-7 ");
    add_text("01");
    add_text("-x");
    add_text(".;");
    add_text("1.2.");
    add_text("3EX");
    add_text("4E?");
    add_text("5E+q");
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b0);
    add_text("9");
    add_item(8'h5A, 1'b1);
    wait_drained();

    // Random: mostly literals, some noise; one full drain partway through.
    while (items_queued < 1775) begin
      if ($urandom_range(0, 9) < 8) add_number_token();
      else add_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      if (!mid_drained && items_queued >= 900) begin
        wait_drained();
        mid_drained = 1'b1;
      end
    end
    wait_drained();
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("numeric_literal_scanner_core: match");
    end else begin
      $display("numeric_literal_scanner_core: mismatch");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("numeric_literal_scanner_core: mismatch");
    $finish;
  end

endmodule
